/* hw/rtl/dcld_pkg.sv */
// Shared types and codes for the discrete command line driver.
// No dependencies; every other file of the block but dcld_ram imports it.
`timescale 1ns / 1ps

package dcld_pkg;

	localparam int DCLD_CMD_DEPTH  = 256;
	localparam int DCLD_PORT_DEPTH = 64;
	localparam int DCLD_LINE_WIDTH = 16;

	localparam logic [1:0] ACT_EXEC      = 2'd0;
	localparam logic [1:0] ACT_LOAD_CMD  = 2'd1;
	localparam logic [1:0] ACT_LOAD_PORT = 2'd2;

	localparam logic [2:0] TYP_STRB   = 3'd0;
	localparam logic [2:0] TYP_STEP   = 3'd1;
	localparam logic [2:0] TYP_SET    = 3'd2;
	localparam logic [2:0] TYP_SELECT = 3'd3;
	localparam logic [2:0] TYP_UNSTRB = 3'd4;
	localparam logic [2:0] TYP_SPARE  = 3'd5;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_STROBE = 2'd1;
	localparam logic [1:0] KIND_WARN   = 2'd2;

	localparam logic [1:0] WARN_NONE    = 2'd0;
	localparam logic [1:0] WARN_SEQ     = 2'd1;
	localparam logic [1:0] WARN_SPARE   = 2'd2;
	localparam logic [1:0] WARN_UNKNOWN = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  typ;
		logic [5:0]  port;
		logic [15:0] mask;
		logic [15:0] fixed;
	} cmd_entry_t;

	typedef struct packed {
		logic cmd_wr;
		logic cmd_rd;
		logic port_wr;
		logic port_rd;
	} mem_ctl_t;

endpackage

/* hw/rtl/discrete_command_line_driver.sv */
// Top level of the discrete command line driver: command table, port shadow table
// and the sequencer. Uses dcld_pkg, dcld_ram and dcld_ctrl.
//
//   channel   | handshake               | fields
//   ----------+-------------------------+----------------------------------------------
//   item in   | start & !busy           | action .. port_address
//   result    | strobe, one cycle each  | kind, bus_address, bus_data, strobe_level,
//             |                         | warning_code, final_res
//
// Load command gives no result. Load port gives its result the next cycle, if its index
// fits the port table. Execute gives n results (0 to 3): the command table is read,
// then the port table, then one result per cycle while the shadow is updated.
// Reset clears the sequencer only; both tables hold nothing valid until loaded.
// Results cannot be stalled; busy falls as the last beat of an item appears on the ports.
`timescale 1ns / 1ps

module discrete_command_line_driver #(
	parameter int CMD_DEPTH  = dcld_pkg::DCLD_CMD_DEPTH,
	parameter int PORT_DEPTH = dcld_pkg::DCLD_PORT_DEPTH,
	parameter int LINE_WIDTH = dcld_pkg::DCLD_LINE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  entry_index,
	input  logic [15:0] value,
	input  logic        first,
	input  logic        last,
	input  logic        clear_phase,
	input  logic [2:0]  entry_type,
	input  logic [5:0]  entry_port,
	input  logic [15:0] entry_mask,
	input  logic [15:0] entry_fixed_value,
	input  logic [15:0] port_address,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [15:0] bus_address,
	output logic [15:0] bus_data,
	output logic        strobe_level,
	output logic [1:0]  warning_code,
	output logic        final_res
);

	import dcld_pkg::*;

	localparam int CAW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int PAW = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1;
	localparam int PW  = 16 + LINE_WIDTH;

	mem_ctl_t        ctl;
	logic [CAW-1:0]  cmd_addr;
	cmd_entry_t      cmd_wr_data, cmd_rd_data;
	logic [PAW-1:0]  port_wr_addr, port_rd_addr;
	logic [PW-1:0]   port_wr_data, port_rd_data;

	dcld_ram #(
		.WIDTH ($bits(cmd_entry_t)),
		.DEPTH (CMD_DEPTH),
		.AW    (CAW)
	) u_cmd_table (
		.clk     (clk),
		.wr_en   (ctl.cmd_wr),
		.wr_addr (cmd_addr),
		.wr_data (cmd_wr_data),
		.rd_en   (ctl.cmd_rd),
		.rd_addr (cmd_addr),
		.rd_data (cmd_rd_data)
	);

	dcld_ram #(
		.WIDTH (PW),
		.DEPTH (PORT_DEPTH),
		.AW    (PAW)
	) u_port_table (
		.clk     (clk),
		.wr_en   (ctl.port_wr),
		.wr_addr (port_wr_addr),
		.wr_data (port_wr_data),
		.rd_en   (ctl.port_rd),
		.rd_addr (port_rd_addr),
		.rd_data (port_rd_data)
	);

	dcld_ctrl #(
		.CMD_DEPTH  (CMD_DEPTH),
		.PORT_DEPTH (PORT_DEPTH),
		.LINE_WIDTH (LINE_WIDTH),
		.CAW        (CAW),
		.PAW        (PAW)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.action            (action),
		.entry_index       (entry_index),
		.value             (value),
		.first             (first),
		.last              (last),
		.clear_phase       (clear_phase),
		.entry_type        (entry_type),
		.entry_port        (entry_port),
		.entry_mask        (entry_mask),
		.entry_fixed_value (entry_fixed_value),
		.port_address      (port_address),
		.strobe            (strobe),
		.kind              (kind),
		.bus_address       (bus_address),
		.bus_data          (bus_data),
		.strobe_level      (strobe_level),
		.warning_code      (warning_code),
		.final_res         (final_res),
		.ctl               (ctl),
		.cmd_addr          (cmd_addr),
		.cmd_wr_data       (cmd_wr_data),
		.cmd_rd_data       (cmd_rd_data),
		.port_wr_addr      (port_wr_addr),
		.port_rd_addr      (port_rd_addr),
		.port_wr_data      (port_wr_data),
		.port_rd_data      (port_rd_data)
	);

endmodule

/* hw/rtl/dcld_ram.sv */
// Single-port-write, single-port-read synchronous table with a registered read.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dcld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/dcld_ctrl.sv */
// Sequencer of the line driver: decodes beats, runs the port shadow read-modify-write
// and serialises results. Uses dcld_pkg; drives the two dcld_ram tables.
`timescale 1ns / 1ps

module dcld_ctrl #(
	parameter int CMD_DEPTH  = dcld_pkg::DCLD_CMD_DEPTH,
	parameter int PORT_DEPTH = dcld_pkg::DCLD_PORT_DEPTH,
	parameter int LINE_WIDTH = dcld_pkg::DCLD_LINE_WIDTH,
	parameter int CAW        = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1,
	parameter int PAW        = (PORT_DEPTH > 1) ? $clog2(PORT_DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [7:0]               entry_index,
	input  logic [15:0]              value,
	input  logic                     first,
	input  logic                     last,
	input  logic                     clear_phase,
	input  logic [2:0]               entry_type,
	input  logic [5:0]               entry_port,
	input  logic [15:0]              entry_mask,
	input  logic [15:0]              entry_fixed_value,
	input  logic [15:0]              port_address,
	output logic                     strobe,
	output logic [1:0]               kind,
	output logic [15:0]              bus_address,
	output logic [15:0]              bus_data,
	output logic                     strobe_level,
	output logic [1:0]               warning_code,
	output logic                     final_res,
	output dcld_pkg::mem_ctl_t       ctl,
	output logic [CAW-1:0]           cmd_addr,
	output dcld_pkg::cmd_entry_t     cmd_wr_data,
	input  dcld_pkg::cmd_entry_t     cmd_rd_data,
	output logic [PAW-1:0]           port_wr_addr,
	output logic [PAW-1:0]           port_rd_addr,
	output logic [16+LINE_WIDTH-1:0] port_wr_data,
	input  logic [16+LINE_WIDTH-1:0] port_rd_data
);

	import dcld_pkg::*;

	localparam logic [LINE_WIDTH-1:0] ONES = {LINE_WIDTH{1'b1}};

	state_t state_q, state_d;

	logic [7:0]  idx_q;
	logic [15:0] val_q;
	logic        first_q, last_q, clr_q;

	logic [2:0]  ptype_q, ptype_d;
	logic        abort_q, abort_d;
	logic [7:0]  strobe_cmd_q, strobe_cmd_d;
	logic [4:0]  pend_q, pend_d;

	logic [1:0]            code_q, code_d;
	logic [PAW-1:0]        port_q;
	logic [LINE_WIDTH-1:0] mask_q, bits_q, shadow_q, shadow_d;

	logic        accept;
	logic        cmd_ok, port_ok, aborted, strobe0, strobe1, dec_warn, dec_w1, dec_w2;
	logic        dec_abort;
	logic [2:0]  ptype;
	logic [1:0]  dec_code;
	cmd_entry_t  ent;
	logic [LINE_WIDTH-1:0] mask_lw, val_lw, dec_mask, dec_bits, cur, nw;
	logic [4:0]  sel, rest;

	logic        strobe_d, out_ld;
	logic [1:0]  kind_d, code_out_d;
	logic [15:0] addr_d, data_d;
	logic        level_d, final_d;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign cmd_addr    = CAW'(entry_index);
	assign cmd_wr_data = '{typ: entry_type, port: entry_port, mask: entry_mask,
	                       fixed: entry_fixed_value};

	// decode of an execute beat once the command entry is back
	always_comb begin
		cmd_ok   = (32'(idx_q) < CMD_DEPTH);
		ent      = cmd_ok ? cmd_rd_data : '0;
		ptype    = first_q ? ent.typ : ptype_q;
		aborted  = first_q ? 1'b0 : abort_q;
		port_ok  = (32'(ent.port) < PORT_DEPTH);
		strobe0  = first_q && (ent.typ == TYP_STRB) && clr_q;
		mask_lw  = LINE_WIDTH'(ent.mask);
		val_lw   = LINE_WIDTH'(val_q);
		dec_w1   = 1'b0;
		dec_w2   = 1'b0;
		dec_warn = strobe0 && (idx_q != strobe_cmd_q);
		dec_code = dec_warn ? WARN_SEQ : WARN_NONE;
		dec_abort = aborted;
		dec_mask = mask_lw;
		dec_bits = '0;
		if (!aborted) begin
			case (ptype)
				TYP_STRB: begin
					dec_w1   = port_ok;
					dec_bits = clr_q ? '0 : ONES;
				end
				TYP_STEP: begin
					dec_w1   = port_ok;
					dec_w2   = port_ok;
					dec_bits = ONES;
				end
				TYP_SET: begin
					dec_w1 = port_ok;
					if (ent.mask != 16'd0) begin
						dec_bits = (val_q != 16'd0) ? ONES : '0;
					end else begin
						dec_mask = val_lw;
						dec_bits = ONES;
					end
				end
				TYP_SELECT: begin
					dec_w1   = port_ok;
					dec_bits = ~val_lw;
				end
				TYP_UNSTRB: begin
					dec_w1   = port_ok;
					dec_bits = LINE_WIDTH'(ent.fixed);
				end
				TYP_SPARE: begin
					dec_abort = 1'b1;
					dec_warn  = 1'b1;
					dec_code  = WARN_SPARE;
				end
				default: begin
					dec_abort = 1'b1;
					dec_warn  = 1'b1;
					dec_code  = WARN_UNKNOWN;
				end
			endcase
		end
		strobe1 = last_q && (ptype == TYP_STRB) && !clr_q;
	end

	// lowest pending result goes first
	always_comb begin
		sel = 5'b00000;
		if (pend_q[0]) begin
			sel = 5'b00001;
		end else if (pend_q[1]) begin
			sel = 5'b00010;
		end else if (pend_q[2]) begin
			sel = 5'b00100;
		end else if (pend_q[3]) begin
			sel = 5'b01000;
		end else if (pend_q[4]) begin
			sel = 5'b10000;
		end
		rest = pend_q & ~sel;
		cur  = sel[3] ? shadow_q : port_rd_data[LINE_WIDTH-1:0];
		nw   = sel[3] ? (cur & ~mask_q) : ((cur & ~mask_q) | (bits_q & mask_q));
	end

	always_comb begin
		state_d      = state_q;
		ptype_d      = ptype_q;
		abort_d      = abort_q;
		strobe_cmd_d = strobe_cmd_q;
		pend_d       = pend_q;
		code_d       = code_q;
		shadow_d     = shadow_q;
		ctl          = '0;
		port_wr_addr = PAW'(entry_index);
		port_rd_addr = PAW'(ent.port);
		port_wr_data = {port_address, LINE_WIDTH'(value)};
		strobe_d     = 1'b0;
		out_ld       = 1'b0;
		kind_d       = KIND_WRITE;
		addr_d       = '0;
		data_d       = '0;
		level_d      = 1'b0;
		code_out_d   = WARN_NONE;
		final_d      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_EXEC: begin
							ctl.cmd_rd = 1'b1;
							state_d    = ST_CMD;
						end
						ACT_LOAD_CMD: begin
							ctl.cmd_wr = (32'(entry_index) < CMD_DEPTH);
						end
						ACT_LOAD_PORT: begin
							if (32'(entry_index) < PORT_DEPTH) begin
								ctl.port_wr = 1'b1;
								strobe_d    = 1'b1;
								out_ld      = 1'b1;
								addr_d      = port_address;
								data_d      = 16'(LINE_WIDTH'(value));
								final_d     = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CMD: begin
				ctl.port_rd = 1'b1;
				ptype_d     = ptype;
				abort_d     = dec_abort;
				code_d      = dec_code;
				if (first_q && (ent.typ == TYP_STRB) && !clr_q) begin
					strobe_cmd_d = idx_q;
				end
				pend_d  = {strobe1, dec_w2, dec_w1, dec_warn, strobe0};
				state_d = (pend_d == 5'b00000) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				strobe_d     = 1'b1;
				out_ld       = 1'b1;
				final_d      = (rest == 5'b00000);
				pend_d       = rest;
				port_wr_addr = port_q;
				port_wr_data = {port_rd_data[16+LINE_WIDTH-1:LINE_WIDTH], nw};
				if (sel[0] || sel[4]) begin
					kind_d  = KIND_STROBE;
					level_d = sel[4];
				end else if (sel[1]) begin
					kind_d     = KIND_WARN;
					code_out_d = code_q;
				end else begin
					ctl.port_wr = 1'b1;
					shadow_d    = nw;
					addr_d      = port_rd_data[16+LINE_WIDTH-1:LINE_WIDTH];
					data_d      = 16'(nw);
				end
				if (rest == 5'b00000) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptype_q      <= TYP_STRB;
			abort_q      <= 1'b0;
			strobe_cmd_q <= '0;
			pend_q       <= '0;
			strobe       <= 1'b0;
		end else begin
			state_q      <= state_d;
			ptype_q      <= ptype_d;
			abort_q      <= abort_d;
			strobe_cmd_q <= strobe_cmd_d;
			pend_q       <= pend_d;
			strobe       <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= entry_index;
			val_q   <= value;
			first_q <= first;
			last_q  <= last;
			clr_q   <= clear_phase;
		end
		if (state_q == ST_CMD) begin
			port_q <= PAW'(ent.port);
			mask_q <= dec_mask;
			bits_q <= dec_bits;
		end
		code_q   <= code_d;
		shadow_q <= shadow_d;
		if (out_ld) begin
			kind         <= kind_d;
			bus_address  <= addr_d;
			bus_data     <= data_d;
			strobe_level <= level_d;
			warning_code <= code_out_d;
			final_res    <= final_d;
		end
	end

`ifndef SYNTHESIS
	a_shadow_write_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.port_wr |=> (strobe && (kind == KIND_WRITE)))
		else $error("port table write without a bus write beat");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !final_res) |=> strobe)
		else $error("result burst broken before its final beat");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && final_res) |=> (!strobe || $past(start && !busy)))
		else $error("result beat after final without a new item");

	a_busy_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 5'b00000) |-> busy)
		else $error("results pending while idle");
`endif

endmodule

/* tb/dcld_result_checker.sv */
// Result checker for the discrete command line driver: predicts every result beat
// from the accepted input beats and compares it field by field. Uses dcld_pkg.
`timescale 1ns / 1ps

module dcld_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  entry_index,
	input  logic [15:0] value,
	input  logic        first,
	input  logic        last,
	input  logic        clear_phase,
	input  logic [2:0]  entry_type,
	input  logic [5:0]  entry_port,
	input  logic [15:0] entry_mask,
	input  logic [15:0] entry_fixed_value,
	input  logic [15:0] port_address,
	input  logic        strobe,
	input  logic [1:0]  kind,
	input  logic [15:0] bus_address,
	input  logic [15:0] bus_data,
	input  logic        strobe_level,
	input  logic [1:0]  warning_code,
	input  logic        final_res,
	output int          mismatches,
	output int          outstanding
);
	import dcld_pkg::*;

	localparam int LW = DCLD_LINE_WIDTH;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [15:0] data;
		logic        lvl;
		logic [1:0]  warn;
		logic        fin;
	} out_beat_t;

	cmd_entry_t    cmd_store [DCLD_CMD_DEPTH];
	logic [15:0]   port_addr [DCLD_PORT_DEPTH];
	logic [LW-1:0] port_shadow [DCLD_PORT_DEPTH];
	logic [2:0]    pkt_type;
	logic          pkt_aborted;
	logic [7:0]    strobe_cmd;

	out_beat_t due_beats[$];
	out_beat_t item_beats [0:3];
	int        item_count;
	int        result_no;

	initial begin
		mismatches = 0;
		outstanding = 0;
		result_no = 0;
	end

	task automatic report(input string what);
		$display("%0t ns: result %0d: %s", $time, result_no, what);
		mismatches++;
	endtask

	task automatic add_beat(input logic [1:0] k, input logic [15:0] a, input logic [15:0] d,
			input logic l, input logic [1:0] w);
		item_beats[item_count] = '{k, a, d, l, w, 1'b0};
		item_count++;
	endtask

	// Merge bits into the masked lines of a port shadow and write it out.
	task automatic shadow_write(input logic [5:0] p, input logic [LW-1:0] m,
			input logic [LW-1:0] bits);
		if (int'(p) < DCLD_PORT_DEPTH) begin
			port_shadow[p] = (port_shadow[p] & ~m) | (bits & m);
			add_beat(KIND_WRITE, port_addr[p], port_shadow[p][15:0], 1'b0, WARN_NONE);
		end
	endtask

	task automatic predict_line_activity();
		cmd_entry_t ce;
		item_count = 0;
		case (action)
			ACT_LOAD_CMD: begin
				cmd_store[entry_index] = '{entry_type, entry_port, entry_mask, entry_fixed_value};
			end
			ACT_LOAD_PORT: begin
				if (int'(entry_index) < DCLD_PORT_DEPTH) begin
					port_addr[entry_index] = port_address;
					port_shadow[entry_index] = value;
					add_beat(KIND_WRITE, port_address, value, 1'b0, WARN_NONE);
				end
			end
			ACT_EXEC: begin
				ce = (int'(entry_index) < DCLD_CMD_DEPTH) ? cmd_store[entry_index] : '0;
				if (first) begin
					pkt_type = ce.typ;
					pkt_aborted = 1'b0;
					if (pkt_type == TYP_STRB) begin
						if (clear_phase) begin
							add_beat(KIND_STROBE, '0, '0, 1'b0, WARN_NONE);
							if (entry_index != strobe_cmd)
								add_beat(KIND_WARN, '0, '0, 1'b0, WARN_SEQ);
						end else begin
							strobe_cmd = entry_index;
						end
					end
				end
				if (!pkt_aborted) begin
					case (pkt_type)
						TYP_STRB: shadow_write(ce.port, ce.mask, clear_phase ? '0 : '1);
						TYP_STEP: begin
							shadow_write(ce.port, ce.mask, '1);
							shadow_write(ce.port, ce.mask, '0);
						end
						TYP_SET: begin
							if (ce.mask != '0)
								shadow_write(ce.port, ce.mask, (value != '0) ? '1 : '0);
							else
								shadow_write(ce.port, value, '1);
						end
						TYP_SELECT: shadow_write(ce.port, ce.mask, ~value);
						TYP_UNSTRB: shadow_write(ce.port, ce.mask, ce.fixed);
						TYP_SPARE: begin
							pkt_aborted = 1'b1;
							add_beat(KIND_WARN, '0, '0, 1'b0, WARN_SPARE);
						end
						default: begin
							pkt_aborted = 1'b1;
							add_beat(KIND_WARN, '0, '0, 1'b0, WARN_UNKNOWN);
						end
					endcase
				end
				if (last && pkt_type == TYP_STRB && !clear_phase)
					add_beat(KIND_STROBE, '0, '0, 1'b1, WARN_NONE);
			end
			default: ;
		endcase
		for (int i = 0; i < item_count; i++) begin
			if (i == item_count - 1)
				item_beats[i].fin = 1'b1;
			due_beats.push_back(item_beats[i]);
		end
	endtask

	task automatic cmp_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result();
		out_beat_t want;
		if (due_beats.size() == 0) begin
			report("result beat with nothing expected");
		end else begin
			want = due_beats.pop_front();
			cmp_field("kind", kind, want.kind);
			cmp_field("bus_address", bus_address, want.addr);
			cmp_field("bus_data", bus_data, want.data);
			cmp_field("strobe_level", strobe_level, want.lvl);
			cmp_field("warning_code", warning_code, want.warn);
			cmp_field("final_res", final_res, want.fin);
		end
		result_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_type = TYP_STRB;
			pkt_aborted = 1'b0;
			strobe_cmd = '0;
		end else begin
			if (strobe)
				check_result();
			if (start && !busy)
				predict_line_activity();
		end
		outstanding = due_beats.size();
	end

endmodule

/* tb/discrete_command_line_driver_tb.sv */
// Testbench top for the discrete command line driver: directed and random command
// beats with random gaps. Needs dcld_pkg, the block and dcld_result_checker.
`timescale 1ns / 1ps

module discrete_command_line_driver_tb;
	import dcld_pkg::*;

	localparam logic [1:0] ACT_NONE      = 2'd3;
	localparam logic [2:0] TYP_UNDEFINED = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 360;
	localparam int IDLE_PCT       = 37;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  idx;
		logic [15:0] value;
		logic        first;
		logic        last;
		logic        clr;
		logic [2:0]  typ;
		logic [5:0]  port;
		logic [15:0] mask;
		logic [15:0] fixed;
		logic [15:0] addr;
	} cmd_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  entry_index;
	logic [15:0] value;
	logic        first;
	logic        last;
	logic        clear_phase;
	logic [2:0]  entry_type;
	logic [5:0]  entry_port;
	logic [15:0] entry_mask;
	logic [15:0] entry_fixed_value;
	logic [15:0] port_address;
	logic        strobe;
	logic [1:0]  kind;
	logic [15:0] bus_address;
	logic [15:0] bus_data;
	logic        strobe_level;
	logic [1:0]  warning_code;
	logic        final_res;

	int mismatches;
	int outstanding;
	int idle_run = 0;
	int work_items = 0;
	int idle_pct = IDLE_PCT;

	bit         cmd_valid [DCLD_CMD_DEPTH];
	logic [2:0] cmd_kind [DCLD_CMD_DEPTH];
	logic [5:0] cmd_home [DCLD_CMD_DEPTH];
	bit         port_valid [DCLD_PORT_DEPTH];

	discrete_command_line_driver DUT (.*);

	dcld_result_checker checker_i (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
	end

	initial begin
		wait (idle_run >= WATCHDOG_LIMIT);
		$display("discrete_command_line_driver_tb: FAIL");
		$finish;
	end

	function automatic cmd_beat_t rand_beat();
		cmd_beat_t b;
		b = $bits(cmd_beat_t)'({$urandom, $urandom, $urandom});
		b.action = ACT_EXEC;
		return b;
	endfunction

	function automatic logic [15:0] rand_value();
		return ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_mask();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_port();
		int live[$];
		for (int p = 0; p < DCLD_PORT_DEPTH; p++)
			if (port_valid[p])
				live.push_back(p);
		if (live.size() == 0 || $urandom_range(9) < 2)
			return $urandom_range(DCLD_PORT_DEPTH - 1);
		return live[$urandom_range(live.size() - 1)];
	endfunction

	// Only commands whose own entry and port entry are both loaded may run.
	function automatic int pick_command(input bit any_type, input logic [2:0] want);
		int live[$];
		for (int i = 0; i < DCLD_CMD_DEPTH; i++)
			if (cmd_valid[i] && port_valid[cmd_home[i]] && (any_type || cmd_kind[i] == want))
				live.push_back(i);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(live.size() - 1)];
	endfunction

	task automatic apply(input cmd_beat_t b);
		action <= b.action;
		entry_index <= b.idx;
		value <= b.value;
		first <= b.first;
		last <= b.last;
		clear_phase <= b.clr;
		entry_type <= b.typ;
		entry_port <= b.port;
		entry_mask <= b.mask;
		entry_fixed_value <= b.fixed;
		port_address <= b.addr;
	endtask

	task automatic send(input cmd_beat_t b);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			apply(rand_beat());
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		apply(b);
		@(posedge clk);
		while (busy) @(posedge clk);
		if (!(b.action == ACT_NONE || (b.action == ACT_LOAD_PORT && b.idx >= DCLD_PORT_DEPTH)))
			work_items++;
	endtask

	task automatic load_port(input int p, input logic [15:0] addr, input logic [15:0] dflt);
		cmd_beat_t b;
		b = rand_beat();
		b.action = ACT_LOAD_PORT;
		b.idx = 8'(p);
		b.addr = addr;
		b.value = dflt;
		send(b);
		if (p < DCLD_PORT_DEPTH)
			port_valid[p] = 1'b1;
	endtask

	task automatic load_cmd(input int i, input logic [2:0] t, input logic [5:0] p,
			input logic [15:0] m, input logic [15:0] f);
		cmd_beat_t b;
		b = rand_beat();
		b.action = ACT_LOAD_CMD;
		b.idx = 8'(i);
		b.typ = t;
		b.port = p;
		b.mask = m;
		b.fixed = f;
		send(b);
		cmd_valid[i] = 1'b1;
		cmd_kind[i] = t;
		cmd_home[i] = p;
	endtask

	task automatic exec(input int i, input logic [15:0] v, input bit f, input bit l,
			input bit c);
		cmd_beat_t b;
		b = rand_beat();
		b.idx = 8'(i);
		b.value = v;
		b.first = f;
		b.last = l;
		b.clr = c;
		send(b);
	endtask

	// Strobe packets get a set pass and usually a release pass, now and then
	// released under a freshly picked strobe command.
	task automatic random_packet();
		int members[$];
		int len;
		int lead;
		bit strobed;
		len = $urandom_range(1, 4);
		lead = pick_command(1'b1, '0);
		if (lead < 0)
			return;
		members.push_back(lead);
		repeat (len - 1) members.push_back(pick_command(1'b1, '0));
		strobed = (cmd_kind[lead] == TYP_STRB);
		foreach (members[k])
			exec(members[k], rand_value(), k == 0, k == len - 1,
				strobed ? 1'b0 : 1'($urandom_range(1)));
		if (strobed && $urandom_range(3) != 0) begin
			if ($urandom_range(4) == 0)
				members[0] = pick_command(1'b0, TYP_STRB);
			foreach (members[k])
				exec(members[k], rand_value(), k == 0, k == len - 1, 1'b1);
		end
	endtask

	task automatic random_noise();
		cmd_beat_t b;
		int i;
		case ($urandom_range(2))
			0: begin
				b = rand_beat();
				b.action = ACT_NONE;
				send(b);
			end
			1: begin
				i = pick_command(1'b1, '0);
				if (i >= 0)
					exec(i, rand_value(), 1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
			end
			default: load_port($urandom_range(DCLD_PORT_DEPTH, 255), 16'($urandom),
				16'($urandom));
		endcase
	endtask

	initial begin
		int base;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		{action, entry_index, value, first, last, clear_phase, entry_type, entry_port,
			entry_mask, entry_fixed_value, port_address} = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_port(0, 16'h0000, 16'h0000);
		load_port(DCLD_PORT_DEPTH - 1, 16'hFFFF, 16'hFFFF);
		load_port(200, 16'h1234, 16'h5678);
		random_noise();
		load_cmd(0, TYP_STRB, 6'd63, 16'hFFFF, 16'h0000);
		load_cmd(7, TYP_STRB, 6'd0, 16'h0001, 16'h0000);
		load_cmd(255, TYP_STEP, 6'd0, 16'hA5A5, 16'h0000);
		load_cmd(1, TYP_SET, 6'd0, 16'h0000, 16'h0000);
		load_cmd(2, TYP_SET, 6'd63, 16'h00F0, 16'h0000);
		load_cmd(3, TYP_SELECT, 6'd0, 16'hFFFF, 16'h0000);
		load_cmd(4, TYP_UNSTRB, 6'd63, 16'h0FF0, 16'hFFFF);
		load_cmd(5, TYP_SPARE, 6'd0, 16'hFFFF, 16'h0000);
		load_cmd(6, TYP_UNDEFINED, 6'd63, 16'hFFFF, 16'h0000);
		exec(0, 16'h0000, 1, 1, 0);
		exec(0, 16'h0000, 1, 1, 1);
		exec(7, 16'h0000, 1, 1, 1);
		exec(255, 16'hFFFF, 1, 1, 0);
		exec(1, 16'hFFFF, 1, 0, 0);
		exec(2, 16'h0000, 0, 1, 0);
		exec(2, 16'h0001, 1, 1, 0);
		exec(3, 16'h1234, 1, 1, 0);
		exec(4, 16'h0000, 1, 1, 0);
		exec(5, 16'h0000, 1, 0, 0);
		exec(3, 16'h0000, 0, 1, 0);
		exec(6, 16'h0000, 1, 1, 1);
		exec(1, 16'hFFFF, 0, 0, 0);

		base = work_items;
		while (work_items - base < RANDOM_ITEMS) begin
			idle_pct = (work_items - base >= 120 && work_items - base < 200) ? 0 : IDLE_PCT;
			pick = $urandom_range(99);
			if (pick < 12)
				load_port(($urandom_range(6) == 0) ? $urandom_range(DCLD_PORT_DEPTH, 255)
					: $urandom_range(DCLD_PORT_DEPTH - 1), 16'($urandom), 16'($urandom));
			else if (pick < 27)
				load_cmd($urandom_range(DCLD_CMD_DEPTH - 1),
					($urandom_range(4) == 0) ? 3'($urandom_range(5, 7))
						: 3'($urandom_range(0, 4)),
					6'(pick_port()), rand_mask(), 16'($urandom));
			else if (pick < 90)
				random_packet();
			else
				random_noise();
		end
		start <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("discrete_command_line_driver_tb: PASS");
		else
			$display("discrete_command_line_driver_tb: FAIL");
		$finish;
	end

endmodule

/* discrete_command_line_driver.f */
hw/rtl/dcld_pkg.sv
hw/rtl/dcld_ram.sv
hw/rtl/dcld_ctrl.sv
hw/rtl/discrete_command_line_driver.sv
tb/dcld_result_checker.sv
tb/discrete_command_line_driver_tb.sv
